/* rtl/tccw_pkg.sv */
// tccw_pkg: types and constants shared by the text console cell writer
// depends on nothing; imported by rtl/text_console_cell_writer.sv
package tccw_pkg;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] char_code;
        logic [7:0] color;
        logic [6:0] col;
        logic [4:0] row;
    } cmd_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_color;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
    } result_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_COPY_LAST,
        ST_FILL
    } state_t;

    localparam logic [15:0] BLANK_CELL = 16'h0020;

endpackage

/* rtl/text_console_cell_writer.sv */
// text_console_cell_writer: text console engine over a ROWS x COLS cell memory
// depends on rtl/tccw_pkg.sv for the command, result and state types
//
// A command beat is taken when start is high and busy is low; each command
// gives one result beat, shown for one cycle with done high, and the
// receiver cannot stall it. Put character without scroll and set cursor
// may follow each other in every cycle; their result appears the cycle
// after the command. Read cell passes through the registered read port of
// the cell memory and then the result register. A put character that runs
// past the last row scrolls: rows below the first are copied one row up
// through the single read and single write port of the memory, one cell per
// cycle, and the last row is then blanked, all while busy is high. Clear
// screen keeps busy high while it blanks every cell. After reset a clearing
// pass fills the memory with blank cells while busy is high.
module text_console_cell_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tccw_pkg::cmd_t    cmd,
    output logic              done,
    output tccw_pkg::result_t result
);
    import tccw_pkg::*;

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW0 = ADDR_W'(CELLS - COLS);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLS);
    localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(ROWS - 1);

    logic [15:0] mem [CELLS];

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ADDR_W-1:0] cur_addr_reg, cur_addr_next;
    logic [ADDR_W-1:0] walk_reg, walk_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic              cp_vld_reg, cp_vld_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;
    logic [15:0]       rd_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [15:0]       mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    logic [COL_W-1:0]  col_c;
    logic [ROW_W-1:0]  row_c;
    logic [ADDR_W-1:0] pos_addr;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // clamped position from the command
    always_comb
    begin
        col_c    = (int'(cmd.col) >= COLS) ? COL_MAX : COL_W'(cmd.col);
        row_c    = (int'(cmd.row) >= ROWS) ? ROW_MAX : ROW_W'(cmd.row);
        pos_addr = ADDR_W'(int'(row_c) * COLS + int'(col_c));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            cur_addr_reg <= '0;
            walk_reg     <= '0;
            cp_vld_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            cur_addr_reg <= cur_addr_next;
            walk_reg     <= walk_next;
            cp_vld_reg   <= cp_vld_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg    <= dst_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        cur_addr_next = cur_addr_reg;
        walk_next     = walk_reg;
        dst_next      = dst_reg;
        cp_vld_next   = cp_vld_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        mem_we        = 1'b0;
        mem_wa        = walk_reg;
        mem_wd        = BLANK_CELL;
        mem_re        = 1'b0;
        mem_ra        = pos_addr;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                walk_next = walk_reg + 1'b1;
                if (walk_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    result_next            = '0;
                    result_next.cursor_col = 7'(cur_col_reg);
                    result_next.cursor_row = 5'(cur_row_reg);
                    unique case (cmd.action)
                        ACT_PUT:
                        begin
                            mem_we = 1'b1;
                            mem_wa = cur_addr_reg;
                            mem_wd = {cmd.color, cmd.char_code};
                            done_next = 1'b1;
                            cur_addr_next = cur_addr_reg + 1'b1;
                            if (cur_col_reg == COL_MAX)
                            begin
                                cur_col_next = '0;
                                if (cur_row_reg == ROW_MAX)
                                begin
                                    // scroll: move rows up, then blank the last
                                    cur_addr_next        = LAST_ROW0;
                                    walk_next            = ROW_STEP;
                                    cp_vld_next          = 1'b0;
                                    done_next            = 1'b0;
                                    result_next.scrolled = 1'b1;
                                    state_next           = ST_COPY;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                            result_next.cursor_col = 7'(cur_col_next);
                            result_next.cursor_row = 5'(cur_row_next);
                        end
                        ACT_SET:
                        begin
                            cur_col_next           = col_c;
                            cur_row_next           = row_c;
                            cur_addr_next          = pos_addr;
                            result_next.cursor_col = 7'(col_c);
                            result_next.cursor_row = 5'(row_c);
                            done_next              = 1'b1;
                        end
                        ACT_CLEAR:
                        begin
                            cur_col_next           = '0;
                            cur_row_next           = '0;
                            cur_addr_next          = '0;
                            walk_next              = '0;
                            result_next.cursor_col = '0;
                            result_next.cursor_row = '0;
                            state_next             = ST_FILL;
                        end
                        ACT_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                result_next.cell_char  = rd_data_reg[7:0];
                result_next.cell_color = rd_data_reg[15:8];
                done_next              = 1'b1;
                state_next             = ST_IDLE;
            end

            ST_COPY:
            begin
                // walk_reg is the source; the previous read lands one row up
                mem_re      = 1'b1;
                mem_ra      = walk_reg;
                mem_we      = cp_vld_reg;
                mem_wa      = dst_reg;
                mem_wd      = rd_data_reg;
                dst_next    = walk_reg - ROW_STEP;
                cp_vld_next = 1'b1;
                walk_next   = walk_reg + 1'b1;
                if (walk_reg == LAST_ADDR)
                begin
                    state_next = ST_COPY_LAST;
                end
            end

            ST_COPY_LAST:
            begin
                mem_we      = 1'b1;
                mem_wa      = dst_reg;
                mem_wd      = rd_data_reg;
                cp_vld_next = 1'b0;
                walk_next   = LAST_ROW0;
                state_next  = ST_FILL;
            end

            ST_FILL:
            begin
                mem_we    = 1'b1;
                walk_next = walk_reg + 1'b1;
                if (walk_reg == LAST_ADDR)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
